[rtl/fpscv_pkg.sv]
// Shared constants, types and the arctangent table of the camera view block.
// Used by the channel interfaces, the CORDIC pipeline and the top level.
`timescale 1ns / 1ps

package fpscv_pkg;

    localparam int POS_WIDTH_DEF      = 32;
    localparam int AXIS_FRAC_BITS_DEF = 16;
    localparam int TRIG_STAGES_DEF    = 16;

    localparam int MAX_STAGES    = 24;
    localparam int TURN_UNITS    = 2 * 180 * 64;
    localparam int QUARTER_UNITS = TURN_UNITS / 4;
    localparam int ANGLE_EXTRA   = 16;
    localparam int SPLIT_BITS    = 24;
    localparam int CORDIC_FRAC   = 30;

    // CORDIC datapath: x, y in Q2.30 plus guard, z in units of 2^-22 degree
    localparam int CW = 34;
    localparam int ZW = 32;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    typedef logic [1:0] quad_t;
    localparam quad_t QUAD_0 = 2'd0;
    localparam quad_t QUAD_1 = 2'd1;
    localparam quad_t QUAD_2 = 2'd2;
    localparam quad_t QUAD_3 = 2'd3;

    // atan(2^-i) in units of 2^-22 degree
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0:  r = ZW'(188743680);
                1:  r = ZW'(111421900);
                2:  r = ZW'(58872272);
                3:  r = ZW'(29884485);
                4:  r = ZW'(15000234);
                5:  r = ZW'(7507429);
                6:  r = ZW'(3754631);
                7:  r = ZW'(1877430);
                8:  r = ZW'(938729);
                9:  r = ZW'(469366);
                10: r = ZW'(234683);
                11: r = ZW'(117342);
                12: r = ZW'(58671);
                13: r = ZW'(29335);
                14: r = ZW'(14668);
                15: r = ZW'(7334);
                16: r = ZW'(3667);
                17: r = ZW'(1833);
                18: r = ZW'(917);
                19: r = ZW'(458);
                20: r = ZW'(229);
                21: r = ZW'(115);
                22: r = ZW'(57);
                default: r = ZW'(29);
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/fpscv_pose_if.sv]
// Input channel: pitch, yaw and camera position word with valid/ready.
// Depends on fpscv_pkg for the default position width.
`timescale 1ns / 1ps

interface fpscv_pose_if #(
    parameter int POS_WIDTH = fpscv_pkg::POS_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          pitch_angle;
    logic signed [15:0]          yaw_angle;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;

    modport source (output valid, pitch_angle, yaw_angle, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pitch_angle, yaw_angle, pos_x, pos_y, pos_z, output ready);
endinterface

[rtl/fpscv_view_if.sv]
// Output channel: camera axes and translations word with valid/ready.
// Depends on fpscv_pkg for the default axis fraction width.
`timescale 1ns / 1ps

interface fpscv_view_if #(
    parameter int AXIS_FRAC_BITS = fpscv_pkg::AXIS_FRAC_BITS_DEF
);
    localparam int AW = AXIS_FRAC_BITS + 2;

    logic                 valid;
    logic                 ready;
    logic signed [AW-1:0] right_x;
    logic signed [AW-1:0] right_y;
    logic signed [AW-1:0] right_z;
    logic signed [AW-1:0] up_x;
    logic signed [AW-1:0] up_y;
    logic signed [AW-1:0] up_z;
    logic signed [AW-1:0] fwd_x;
    logic signed [AW-1:0] fwd_y;
    logic signed [AW-1:0] fwd_z;
    logic signed [31:0]   trans_right;
    logic signed [31:0]   trans_up;
    logic signed [31:0]   trans_fwd;

    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    fwd_x, fwd_y, fwd_z, trans_right, trans_up, trans_fwd, input ready);
    modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    fwd_x, fwd_y, fwd_z, trans_right, trans_up, trans_fwd, output ready);
endinterface

[rtl/fpscv_cordic.sv]
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// Depends on fpscv_pkg for datapath widths, gain and arctangent table.
`timescale 1ns / 1ps

module fpscv_cordic #(
    parameter int NST = 16
) (
    input  logic                          clk,
    input  logic [NST-1:0]                en,
    input  logic signed [fpscv_pkg::ZW-1:0] z_in,
    output logic signed [fpscv_pkg::CW-1:0] x_out,
    output logic signed [fpscv_pkg::CW-1:0] y_out
);
    localparam int CW = fpscv_pkg::CW;
    localparam int ZW = fpscv_pkg::ZW;

    logic signed [CW-1:0] x_reg [NST];
    logic signed [CW-1:0] y_reg [NST];

    genvar i;
    generate
        for (i = 0; i < NST; i++) begin : g_stage
            logic signed [CW-1:0] xi, yi, x_next, y_next;
            logic signed [ZW-1:0] zi, z_next;
            logic signed [ZW-1:0] z_q_w;
            wire  signed [ZW-1:0] z_q = z_q_w;

            if (i == 0) begin : g_first
                assign xi = fpscv_pkg::CORDIC_GAIN;
                assign yi = '0;
                assign zi = z_in;
            end else begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = g_stage[i-1].z_q;
            end

            always_comb
            begin
                // zero residue rotates as positive
                if (!zi[ZW-1])
                begin
                    x_next = xi - (yi >>> i);
                    y_next = yi + (xi >>> i);
                    z_next = zi - fpscv_pkg::atan_val(i);
                end
                else
                begin
                    x_next = xi + (yi >>> i);
                    y_next = yi - (xi >>> i);
                    z_next = zi + fpscv_pkg::atan_val(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                end
            end

            if (i < NST - 1) begin : g_z
                logic signed [ZW-1:0] z_reg;
                always_ff @(posedge clk)
                begin
                    if (en[i])
                        z_reg <= z_next;
                end
            end

            if (i < NST - 1) begin : g_zq
                assign z_q_w = g_z.z_reg;
            end else begin : g_zl
                assign z_q_w = '0;
            end
        end
    endgenerate

    assign x_out = x_reg[NST-1];
    assign y_out = y_reg[NST-1];

endmodule

[rtl/fps_camera_view_matrix.sv]
// Top level: angle reduction, two CORDIC pipelines, axis products, translations.
// Depends on fpscv_pkg, fpscv_pose_if, fpscv_view_if and fpscv_cordic.
`timescale 1ns / 1ps
//
//  channel | dir | word
//  pose    | in  | pitch_angle, yaw_angle, pos_x, pos_y, pos_z
//  view    | out | nine axis entries, trans_right, trans_up, trans_fwd
//
//  One word enters per cycle while pose.ready is high; the pipeline holds the
//  unrolled CORDIC stages (TRIG_STAGES, 24 stages max) plus reduce, quantize,
//  product and three translation stages. Every stage has its own valid bit and fills bubbles
//  while the output is held; pose.ready drops only when every stage is full.
//  Reset clears the valid bits only.

module fps_camera_view_matrix #(
    parameter int POS_WIDTH      = fpscv_pkg::POS_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = fpscv_pkg::AXIS_FRAC_BITS_DEF,
    parameter int TRIG_STAGES    = fpscv_pkg::TRIG_STAGES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    fpscv_pose_if.sink   pose,
    fpscv_view_if.source view
);
    localparam int CW   = fpscv_pkg::CW;
    localparam int ZW   = fpscv_pkg::ZW;
    localparam int AFB  = AXIS_FRAC_BITS;
    localparam int AW   = AFB + 2;
    localparam int NST  = (TRIG_STAGES > fpscv_pkg::MAX_STAGES) ?
                          fpscv_pkg::MAX_STAGES : TRIG_STAGES;
    localparam int NS   = NST + 6;
    localparam int SQ   = NST + 1;
    localparam int SM   = NST + 2;
    localparam int ST1  = NST + 3;
    localparam int ST2  = NST + 4;
    localparam int SO   = NST + 5;
    localparam int NPOS = NST + 3;

    localparam int SH   = fpscv_pkg::CORDIC_FRAC - AFB;
    localparam int SPL  = fpscv_pkg::SPLIT_BITS;
    localparam int EXTW = (POS_WIDTH > SPL + 1) ? POS_WIDTH : SPL + 1;
    localparam int PHW  = EXTW - SPL;
    localparam int HPW  = AW + PHW;
    localparam int LPW  = AW + SPL + 1;
    localparam int HCW  = 42;
    localparam int HSW  = (HPW + 2 > HCW) ? HPW + 2 : HCW;
    localparam int LSW  = LPW + 3;
    localparam int VW   = HCW + SPL - AFB + 2;

    localparam logic signed [CW:0]    ONE_Q  = (CW+1)'(2**AFB);
    localparam logic signed [CW:0]    HALF_Q = (CW+1)'(2**(SH-1));
    localparam logic signed [AW-1:0]  ONE_AX = AW'(2**AFB);
    localparam logic signed [2*AW-1:0] HALF_M = (2*AW)'(2**(AFB-1));
    localparam logic signed [HSW-1:0] HI_LIM = HSW'(64'd1 << 40);
    localparam logic signed [LSW-1:0] HALF_L = LSW'(2**(AFB-1));
    localparam logic signed [VW-1:0]  SAT_HI = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0]  SAT_LO = -VW'(64'sd2147483648);

    typedef logic [12:0] rem_t;

    function automatic void reduce_angle(input logic signed [15:0] a,
                                         output fpscv_pkg::quad_t q,
                                         output rem_t rem);
        logic signed [17:0] r;
        begin
            r = 18'(a);
            if (r < 0)
                r = r + 18'(fpscv_pkg::TURN_UNITS);
            if (r < 0)
                r = r + 18'(fpscv_pkg::TURN_UNITS);
            if (r >= 18'(fpscv_pkg::TURN_UNITS))
                r = r - 18'(fpscv_pkg::TURN_UNITS);
            priority if (r >= 18'(3 * fpscv_pkg::QUARTER_UNITS))
            begin
                q = fpscv_pkg::QUAD_3;
                r = r - 18'(3 * fpscv_pkg::QUARTER_UNITS);
            end
            else if (r >= 18'(2 * fpscv_pkg::QUARTER_UNITS))
            begin
                q = fpscv_pkg::QUAD_2;
                r = r - 18'(2 * fpscv_pkg::QUARTER_UNITS);
            end
            else if (r >= 18'(fpscv_pkg::QUARTER_UNITS))
            begin
                q = fpscv_pkg::QUAD_1;
                r = r - 18'(fpscv_pkg::QUARTER_UNITS);
            end
            else
                q = fpscv_pkg::QUAD_0;
            rem = r[12:0];
        end
    endfunction

    function automatic logic signed [AW-1:0] quantize(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        begin
            t = ((CW+1)'(v) + HALF_Q) >>> SH;
            if (t > ONE_Q)
                t = ONE_Q;
            else if (t < -ONE_Q)
                t = -ONE_Q;
            return t[AW-1:0];
        end
    endfunction

    function automatic logic signed [AW-1:0] mul_round(input logic signed [AW-1:0] a,
                                                       input logic signed [AW-1:0] b);
        logic signed [2*AW-1:0] p;
        begin
            p = ((2*AW)'(a) * (2*AW)'(b) + HALF_M) >>> AFB;
            return p[AW-1:0];
        end
    endfunction

    // ---------------- handshake ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en_s;

    always_comb
    begin
        en_s[NS-1] = !vld_reg[NS-1] || view.ready;
        for (int k = NS - 2; k >= 0; k--)
            en_s[k] = !vld_reg[k] || en_s[k+1];
    end

    assign pose.ready = en_s[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en_s[0])
                vld_reg[0] <= pose.valid;
            for (int k = 1; k < NS; k++)
                if (en_s[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- reduce stage ----------------
    fpscv_pkg::quad_t qp_next, qy_next;
    rem_t             rp_next, ry_next;
    rem_t             rp_reg, ry_reg;
    fpscv_pkg::quad_t qp_pipe [NST+1];
    fpscv_pkg::quad_t qy_pipe [NST+1];
    logic signed [POS_WIDTH-1:0] pos_pipe [NPOS][3];

    always_comb
    begin
        reduce_angle(pose.pitch_angle, qp_next, rp_next);
        reduce_angle(pose.yaw_angle, qy_next, ry_next);
    end

    always_ff @(posedge clk)
    begin
        if (en_s[0])
        begin
            rp_reg        <= rp_next;
            ry_reg        <= ry_next;
            qp_pipe[0]    <= qp_next;
            qy_pipe[0]    <= qy_next;
            pos_pipe[0][0] <= pose.pos_x;
            pos_pipe[0][1] <= pose.pos_y;
            pos_pipe[0][2] <= pose.pos_z;
        end
        for (int k = 1; k <= NST; k++)
            if (en_s[k])
            begin
                qp_pipe[k] <= qp_pipe[k-1];
                qy_pipe[k] <= qy_pipe[k-1];
            end
        for (int k = 1; k < NPOS; k++)
            if (en_s[k])
                pos_pipe[k] <= pos_pipe[k-1];
    end

    // ---------------- CORDIC ----------------
    logic signed [CW-1:0] xp, yp, xy, yy;

    fpscv_cordic #(.NST(NST)) u_cordic_pitch (
        .clk   (clk),
        .en    (en_s[NST:1]),
        .z_in  (ZW'({rp_reg, fpscv_pkg::ANGLE_EXTRA'(0)})),
        .x_out (xp),
        .y_out (yp)
    );

    fpscv_cordic #(.NST(NST)) u_cordic_yaw (
        .clk   (clk),
        .en    (en_s[NST:1]),
        .z_in  (ZW'({ry_reg, fpscv_pkg::ANGLE_EXTRA'(0)})),
        .x_out (xy),
        .y_out (yy)
    );

    // ---------------- quantize and quadrant ----------------
    logic signed [AW-1:0] sp_next, cp_next, sy_next, cy_next;
    logic signed [AW-1:0] sp_reg, cp_reg, sy_reg, cy_reg;

    function automatic void quad_map(input fpscv_pkg::quad_t q,
                                     input logic signed [AW-1:0] cq,
                                     input logic signed [AW-1:0] sq,
                                     output logic signed [AW-1:0] c,
                                     output logic signed [AW-1:0] s);
        begin
            unique case (q)
                fpscv_pkg::QUAD_0: begin c = cq;  s = sq;  end
                fpscv_pkg::QUAD_1: begin c = -sq; s = cq;  end
                fpscv_pkg::QUAD_2: begin c = -cq; s = -sq; end
                fpscv_pkg::QUAD_3: begin c = sq;  s = -cq; end
                default:           begin c = cq;  s = sq;  end
            endcase
        end
    endfunction

    always_comb
    begin
        quad_map(qp_pipe[NST], quantize(xp), quantize(yp), cp_next, sp_next);
        quad_map(qy_pipe[NST], quantize(xy), quantize(yy), cy_next, sy_next);
    end

    always_ff @(posedge clk)
    begin
        if (en_s[SQ])
        begin
            sp_reg <= sp_next;
            cp_reg <= cp_next;
            sy_reg <= sy_next;
            cy_reg <= cy_next;
        end
    end

    // ---------------- axis products ----------------
    logic signed [AW-1:0] ax_next [9];
    logic signed [AW-1:0] ax_reg  [9];
    logic signed [AW-1:0] ax1_reg [9];
    logic signed [AW-1:0] ax2_reg [9];
    logic signed [AW-1:0] ax3_reg [9];

    always_comb
    begin
        ax_next[0] = cy_reg;
        ax_next[1] = '0;
        ax_next[2] = -sy_reg;
        ax_next[3] = mul_round(sy_reg, sp_reg);
        ax_next[4] = cp_reg;
        ax_next[5] = mul_round(cy_reg, sp_reg);
        ax_next[6] = mul_round(sy_reg, cp_reg);
        ax_next[7] = -sp_reg;
        ax_next[8] = mul_round(cp_reg, cy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_s[SM])
            ax_reg <= ax_next;
        if (en_s[ST1])
            ax1_reg <= ax_reg;
        if (en_s[ST2])
            ax2_reg <= ax1_reg;
        if (en_s[SO])
            ax3_reg <= ax2_reg;
    end

    // ---------------- translation: partial products ----------------
    logic signed [HPW-1:0] hp_next [3][3];
    logic signed [LPW-1:0] lp_next [3][3];
    logic signed [HPW-1:0] hp_reg  [3][3];
    logic signed [LPW-1:0] lp_reg  [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                logic signed [EXTW-1:0] pe;
                pe = EXTW'(pos_pipe[NPOS-1][c]);
                hp_next[r][c] = HPW'(ax_reg[3*r+c]) * HPW'($signed(pe[EXTW-1:SPL]));
                lp_next[r][c] = LPW'(ax_reg[3*r+c]) * $signed({1'b0, pe[SPL-1:0]});
            end
    end

    always_ff @(posedge clk)
    begin
        if (en_s[ST1])
        begin
            hp_reg <= hp_next;
            lp_reg <= lp_next;
        end
    end

    // ---------------- translation: sums ----------------
    logic signed [HCW-1:0] hi_next [3];
    logic signed [LSW-1:0] lo_next [3];
    logic signed [HCW-1:0] hi_reg  [3];
    logic signed [LSW-1:0] lo_reg  [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [HSW-1:0] hs;
            hs = HSW'(hp_reg[r][0]) + HSW'(hp_reg[r][1]) + HSW'(hp_reg[r][2]);
            if (hs > HI_LIM)
                hs = HI_LIM;
            else if (hs < -HI_LIM)
                hs = -HI_LIM;
            hi_next[r] = hs[HCW-1:0];
            lo_next[r] = LSW'(lp_reg[r][0]) + LSW'(lp_reg[r][1]) + LSW'(lp_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s[ST2])
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // ---------------- translation: combine, negate, saturate ----------------
    logic signed [31:0] tr_next [3];
    logic signed [31:0] tr_reg  [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [VW-1:0]  v;
            logic signed [LSW-1:0] lr;
            lr = (lo_reg[r] + HALF_L) >>> AFB;
            v  = -((VW'(hi_reg[r]) <<< (SPL - AFB)) + VW'(lr));
            if (v > SAT_HI)
                v = SAT_HI;
            else if (v < SAT_LO)
                v = SAT_LO;
            tr_next[r] = v[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s[SO])
            tr_reg <= tr_next;
    end

    assign view.valid       = vld_reg[NS-1];
    assign view.right_x     = ax3_reg[0];
    assign view.right_y     = ax3_reg[1];
    assign view.right_z     = ax3_reg[2];
    assign view.up_x        = ax3_reg[3];
    assign view.up_y        = ax3_reg[4];
    assign view.up_z        = ax3_reg[5];
    assign view.fwd_x       = ax3_reg[6];
    assign view.fwd_y       = ax3_reg[7];
    assign view.fwd_z       = ax3_reg[8];
    assign view.trans_right = tr_reg[0];
    assign view.trans_up    = tr_reg[1];
    assign view.trans_fwd   = tr_reg[2];

`ifndef NO_ASSERTIONS
    a_right_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        view.valid |-> view.right_y == '0)
        else $error("right_y not zero");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.ready) |=> vld_reg[0])
        else $error("accepted word lost at entry");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en_s[0] |-> &vld_reg)
        else $error("input stalled with a bubble in the pipeline");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        view.valid |-> (view.right_x <= ONE_AX && view.right_x >= -ONE_AX))
        else $error("right_x outside unit range");
`endif

endmodule
